@@ rtl/stbs_pkg.sv @@
// Shared types and constants for the sorted table binary search block.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             qry;
    logic             wr_ok;
    logic             hit;
    logic [KEY_W-1:0] word;
  } stbs_item_t;

endpackage

@@ rtl/stbs_ram.sv @@
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/stbs_level.sv @@
// One search level: midpoint probe into a private table copy, then window update.
`timescale 1ns / 1ps

module stbs_level
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               vld_i,
  input  stbs_item_t                         item_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   lo_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]   hi_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]     idx_i,
  output logic                               vld_o,
  output stbs_item_t                         item_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   lo_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   hi_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     idx_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH+1);

  logic [CW-1:0]    diff;
  logic [CW-1:0]    mid;
  logic             ram_we;
  logic [KEY_W-1:0] rdata;

  logic             b_vld_q;
  stbs_item_t       b_item_q;
  logic [CW-1:0]    b_lo_q;
  logic [CW-1:0]    b_hi_q;
  logic [CW-1:0]    b_mid_q;
  logic [AW-1:0]    b_idx_q;
  logic             act;

  assign diff   = hi_i - lo_i - CW'(1);
  assign mid    = lo_i + (diff >> 1);
  assign ram_we = adv_i && vld_i && (item_i.qry == CMD_WRITE) && item_i.wr_ok;

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_i),
    .wdata_i (item_i.word),
    .re_i    (adv_i),
    .raddr_i (mid[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv_i) begin
      b_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_item_q <= item_i;
      b_lo_q   <= lo_i;
      b_hi_q   <= hi_i;
      b_mid_q  <= mid;
      b_idx_q  <= idx_i;
    end
  end

  assign act = b_vld_q && b_item_q.qry && !b_item_q.hit && (b_lo_q < b_hi_q);

  always_comb begin
    vld_o  = b_vld_q;
    item_o = b_item_q;
    lo_o   = b_lo_q;
    hi_o   = b_hi_q;
    idx_o  = b_idx_q;
    if (act) begin
      if (rdata == b_item_q.word) begin
        item_o.hit = 1'b1;
      end else if (b_item_q.word < rdata) begin
        hi_o = b_mid_q;
      end else begin
        lo_o = b_mid_q + CW'(1);
      end
    end
  end

endmodule

@@ rtl/sorted_table_binary_search.sv @@
// Each search level owns a table copy and a read port, with a registered RAM read and output.
// Throughput: one item per cycle while out_stall_i does not hold a waiting result.
// Writes travel the pipeline and update each level's copy in item order; no result.
// Reset clears valid bits and entry_count; table contents stay undefined until written,
// with no clearing pass, so items are accepted right after reset.
`timescale 1ns / 1ps

module sorted_table_binary_search
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [IDX_W-1:0] entry_index_i,
  input  logic [KEY_W-1:0] entry_value_i,
  input  logic [KEY_W-1:0] query_key_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             found_o
);

  localparam int          AW      = $clog2(TABLE_DEPTH);
  localparam int          CW      = $clog2(TABLE_DEPTH+1);
  localparam int          LEVELS  = CW;
  localparam logic [31:0] DEPTH_W = 32'(TABLE_DEPTH);

  logic [CNT_W-1:0] count_q;
  logic             adv;
  logic [31:0]      cnt_w;
  logic [31:0]      idx_w;

  logic             a_vld_q  [LEVELS+1];
  stbs_item_t       a_item_q [LEVELS+1];
  logic [CW-1:0]    a_lo_q   [LEVELS+1];
  logic [CW-1:0]    a_hi_q   [LEVELS+1];
  logic [AW-1:0]    a_idx_q  [LEVELS+1];

  logic             a_vld_d  [LEVELS+1];
  stbs_item_t       a_item_d [LEVELS+1];
  logic [CW-1:0]    a_lo_d   [LEVELS+1];
  logic [CW-1:0]    a_hi_d   [LEVELS+1];
  logic [AW-1:0]    a_idx_d  [LEVELS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o = a_vld_q[LEVELS] && a_item_q[LEVELS].qry;
  assign found_o     = a_item_q[LEVELS].hit;
  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;

  assign cnt_w = {{(32-CNT_W){1'b0}}, count_q};
  assign idx_w = {{(32-IDX_W){1'b0}}, entry_index_i};

  always_comb begin
    a_vld_d[0]        = in_valid_i;
    a_item_d[0].qry   = (cmd_i == CMD_QUERY);
    a_item_d[0].wr_ok = (idx_w < DEPTH_W);
    a_item_d[0].hit   = 1'b0;
    a_item_d[0].word  = (cmd_i == CMD_WRITE) ? entry_value_i : query_key_i;
    a_lo_d[0]         = '0;
    a_hi_d[0]         = (cnt_w > DEPTH_W) ? DEPTH_W[CW-1:0] : cnt_w[CW-1:0];
    a_idx_d[0]        = idx_w[AW-1:0];
  end

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    stbs_level #(
      .TABLE_DEPTH (TABLE_DEPTH)
    ) u_level (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (a_vld_q[k]),
      .item_i (a_item_q[k]),
      .lo_i   (a_lo_q[k]),
      .hi_i   (a_hi_q[k]),
      .idx_i  (a_idx_q[k]),
      .vld_o  (a_vld_d[k+1]),
      .item_o (a_item_d[k+1]),
      .lo_o   (a_lo_d[k+1]),
      .hi_o   (a_hi_d[k+1]),
      .idx_o  (a_idx_d[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LEVELS; k++) begin
        a_vld_q[k] <= 1'b0;
      end
    end else if (adv) begin
      for (int k = 0; k <= LEVELS; k++) begin
        a_vld_q[k] <= a_vld_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= LEVELS; k++) begin
        a_item_q[k] <= a_item_d[k];
        a_lo_q[k]   <= a_lo_d[k];
        a_hi_q[k]   <= a_hi_d[k];
        a_idx_q[k]  <= a_idx_d[k];
      end
    end
  end

endmodule

@@ rtl/stbs_checker.sv @@
// Port-level checks for the sorted table binary search block, bound to the top level.
`timescale 1ns / 1ps

module stbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic found_o
);

  a_stall_needs_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o
  ) else $error("input stalled with no result waiting");

  a_drain_frees_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o
  ) else $error("input stalled while output side takes items");

  a_result_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(found_o))
  ) else $error("stalled result changed or dropped");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
